// File: hdl/bmmt_pkg.sv
// Package for boot_memory_map_tally: phase codes, status codes, constants.
// No dependencies.
package bmmt_pkg;

	localparam logic [31:0] BOOT_MAGIC = 32'h36D7_6289;
	localparam logic [31:0] TAG_END    = 32'd0;
	localparam logic [31:0] TAG_MMAP   = 32'd6;
	localparam logic [31:0] ENTRY_MIN  = 32'd24;
	localparam int          QUEUE_DEPTH = 2;

	localparam logic [3:0] PH_IDLE      = 4'd0;
	localparam logic [3:0] PH_HEADER    = 4'd1;
	localparam logic [3:0] PH_TAG_TYPE  = 4'd2;
	localparam logic [3:0] PH_TAG_SIZE  = 4'd3;
	localparam logic [3:0] PH_MAP_ESIZE = 4'd4;
	localparam logic [3:0] PH_MAP_EVER  = 4'd5;
	localparam logic [3:0] PH_ENTRY     = 4'd6;
	localparam logic [3:0] PH_SKIP      = 4'd7;
	localparam logic [3:0] PH_DONE      = 4'd8;
	localparam logic [3:0] PH_REJECT    = 4'd9;
	localparam logic [3:0] PH_BAD       = 4'd10;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_WALK    = 3'd1;
	localparam logic [2:0] ST_DONE    = 3'd2;
	localparam logic [2:0] ST_REJECT  = 3'd3;
	localparam logic [2:0] ST_BAD     = 3'd4;

	localparam logic REG_MAGIC   = 1'b0;
	localparam logic REG_PRESENT = 1'b1;

	// one tally snapshot, also the queue payload
	typedef struct packed {
		logic [31:0] mem_total;
		logic [31:0] mem_usable;
		logic [31:0] entry_count;
		logic [2:0]  walk_status;
	} tally_t;

	function automatic logic [2:0] status_of(input logic [3:0] ph);
		logic [2:0] s;
		case (ph)
			PH_IDLE:   s = ST_IDLE;
			PH_DONE:   s = ST_DONE;
			PH_REJECT: s = ST_REJECT;
			PH_BAD:    s = ST_BAD;
			default:   s = ST_WALK;
		endcase
		return s;
	endfunction

endpackage

// File: hdl/bmmt_walk.sv
// Front part: walks tags and entries, one word per beat, and keeps the tallies.
// Depends on bmmt_pkg.
module bmmt_walk import bmmt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [31:0] data_word,
	input  logic        first_word,
	input  logic [31:0] loader_magic,
	input  logic        info_present,
	output tally_t      tally
);

	logic [3:0]  phase_q, ph;
	logic [31:0] pos_q, pos;
	logic [31:0] end_q, end_d;
	logic        map_q, map_d;
	logic [31:0] left_q, left;
	logic [31:0] stride_q, stride_d;
	logic [31:0] off_q, off;
	logic [31:0] low_q, low_d;
	logic [31:0] kib_q, kib_d;
	logic [31:0] pad_q, pad_d;
	logic [31:0] tot_q, tot_d, use_q, use_d, cnt_q, cnt_d;
	logic [31:0] w, alg, ml;
	logic        room;

	assign w = data_word;
	assign alg = (w + 32'd7) & ~32'd7;

	// next-state walk
	always_comb begin
		ph = phase_q; pos = pos_q; end_d = end_q; map_d = map_q; left = left_q;
		stride_d = stride_q; off = off_q; low_d = low_q; kib_d = kib_q;
		pad_d = pad_q; tot_d = tot_q; use_d = use_q; cnt_d = cnt_q;
		ml = 32'd0; room = 1'b0;
		if (first_word) begin
			if (loader_magic != BOOT_MAGIC || !info_present) begin
				ph = PH_REJECT;
			end else begin
				end_d = w; pos = 32'd4; ph = PH_HEADER;
			end
		end else if (phase_q >= PH_HEADER && phase_q <= PH_SKIP) begin
			pos = pos_q + 32'd4;
			room = ({1'b0, pos} + 33'd8) <= {1'b0, end_q};
			if (phase_q != PH_HEADER && phase_q != PH_TAG_TYPE &&
					phase_q != PH_TAG_SIZE)
				left = (left_q >= 32'd4) ? left_q - 32'd4 : 32'd0;
			ml = (left > pad_q) ? left - pad_q : 32'd0;
			case (phase_q)
				PH_HEADER: ph = room ? PH_TAG_TYPE : PH_DONE;
				PH_TAG_TYPE: begin
					if (w == TAG_END) ph = PH_DONE;
					else begin
						map_d = (w == TAG_MMAP); ph = PH_TAG_SIZE;
					end
				end
				PH_TAG_SIZE: begin
					if (alg == 32'd0 || (map_q && w < 32'd16)) ph = PH_BAD;
					else begin
						left = alg - 32'd8;
						if (map_q) begin
							pad_d = alg - w; ph = PH_MAP_ESIZE;
						end else if (left == 32'd0) ph = room ? PH_TAG_TYPE : PH_DONE;
						else ph = PH_SKIP;
					end
				end
				PH_MAP_ESIZE: begin
					if (w < ENTRY_MIN || w[1:0] != 2'b00) ph = PH_BAD;
					else begin
						stride_d = w; ph = PH_MAP_EVER;
					end
				end
				PH_MAP_EVER: begin
					if (ml == 32'd0) begin
						if (left == 32'd0) ph = room ? PH_TAG_TYPE : PH_DONE;
						else ph = PH_SKIP;
					end else if (ml < ENTRY_MIN) ph = PH_BAD;
					else begin
						off = 32'd0; ph = PH_ENTRY;
					end
				end
				PH_ENTRY: begin
					if (off_q == 32'd8) low_d = w;
					else if (off_q == 32'd12) begin
						kib_d = (w[31:10] != 22'd0) ? 32'hFFFF_FFFF :
							{w[9:0], low_q[31:10]};
					end else if (off_q == 32'd16) begin
						tot_d = tot_q + kib_q;
						if (w == 32'd1) use_d = use_q + kib_q;
						cnt_d = cnt_q + 32'd1;
					end
					off = off_q + 32'd4;
					if ((off >= ENTRY_MIN && ml == 32'd0) ||
							(off == stride_q && ml == 32'd0)) begin
						if (left == 32'd0) ph = room ? PH_TAG_TYPE : PH_DONE;
						else ph = PH_SKIP;
					end else if (off == stride_q) begin
						if (ml < ENTRY_MIN) ph = PH_BAD;
						else off = 32'd0;
					end
				end
				default: begin
					if (left == 32'd0) ph = room ? PH_TAG_TYPE : PH_DONE;
				end
			endcase
		end
	end

	// commit on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; pos_q <= '0; end_q <= '0; map_q <= 1'b0;
			left_q <= '0; stride_q <= '0; off_q <= '0; low_q <= '0;
			kib_q <= '0; pad_q <= '0; tot_q <= '0; use_q <= '0; cnt_q <= '0;
		end else if (take) begin
			phase_q <= ph; pos_q <= pos; end_q <= end_d; map_q <= map_d;
			left_q <= left; stride_q <= stride_d; off_q <= off; low_q <= low_d;
			kib_q <= kib_d; pad_q <= pad_d; tot_q <= tot_d; use_q <= use_d;
			cnt_q <= cnt_d;
		end
	end

	assign tally = '{mem_total: tot_d, mem_usable: use_d, entry_count: cnt_d,
		walk_status: status_of(ph)};

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + 32'd1))
		else $error("entry count jumped");
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(take && first_word && loader_magic != BOOT_MAGIC) |=> phase_q == PH_REJECT)
		else $error("bad magic not rejected");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(tot_q) && $stable(phase_q))
		else $error("state moved without a beat");

endmodule

// File: hdl/bmmt_queue.sv
// Back part: short result queue between the walker and the output channel.
// Depends on bmmt_pkg.
module bmmt_queue import bmmt_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  tally_t push_data,
	output logic   full,
	output logic   out_valid,
	input  logic   out_stall,
	output tally_t out_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	tally_t          mem_q [DEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [AW:0]     cnt_q;
	logic            pop;

	assign pop = out_valid && !out_stall;
	assign out_valid = (cnt_q != '0);
	assign full = (cnt_q == (AW+1)'(DEPTH));
	assign out_data = mem_q[rd_q];

	// store the entry
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("queue overflow");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH)) else $error("fill count out of range");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> cnt_q == $past(cnt_q) - 1'b1) else $error("pop lost");

endmodule

// File: hdl/boot_memory_map_tally.sv
// Top level: boot memory map tally, walker front part plus result queue.
// Depends on bmmt_pkg, bmmt_walk, bmmt_queue.
//
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | data_word, first_word
//  out     | out_valid / out_stall| mem_total, mem_usable, entry_count, walk_status
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One word per cycle while in_stall is low; each accepted word yields one result
// in a queue DEPTH deep (two by default) behind older ones. The walker takes a word
// whenever the queue has room, so in_stall rises only when the queue is full.
// Reset clears tallies, walk phase and registers; config is always ready.
module boot_memory_map_tally import bmmt_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] data_word,
	input  logic        first_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] mem_total,
	output logic [31:0] mem_usable,
	output logic [31:0] entry_count,
	output logic [2:0]  walk_status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	logic [31:0] magic_q;
	logic        present_q;
	logic        full, take;
	tally_t      next_tally, head;

	assign cfg_ready = 1'b1;
	assign in_stall = full;
	assign take = in_valid && !full;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= '0; present_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MAGIC:   magic_q <= cfg_data;
				REG_PRESENT: present_q <= cfg_data[0];
				default:     ;
			endcase
		end
	end

	bmmt_walk u_walk (
		.clk(clk), .arst_n(arst_n), .take(take), .data_word(data_word),
		.first_word(first_word), .loader_magic(magic_q),
		.info_present(present_q), .tally(next_tally)
	);

	bmmt_queue #(.DEPTH(DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(take), .push_data(next_tally),
		.full(full), .out_valid(out_valid), .out_stall(out_stall), .out_data(head)
	);

	assign mem_total = head.mem_total;
	assign mem_usable = head.mem_usable;
	assign entry_count = head.entry_count;
	assign walk_status = head.walk_status;

endmodule
